/* rtl/core/ttg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttg_pkg: shared types and constants
// Widths, register indexes and controller/datapath command/status structs.
// ----------------------------------------------------------------------------
package ttg_pkg;

	localparam int CoordWidth = 16;
	localparam int FracBits   = 12;
	localparam int EpsFrac    = 24;
	localparam int NormBits   = 30;
	localparam int DeltaWidth = CoordWidth + 1;
	localparam int ProdWidth  = 2 * DeltaWidth;
	localparam int DetWidth   = ProdWidth + 1;
	localparam int EpsWidth   = 33;
	localparam int OutWidth   = 16;
	localparam int SumWidth   = 2 * NormBits + 2;
	localparam int RootWidth  = NormBits + 1;
	localparam int QuoWidth   = 15;

	localparam logic [0:0] RegEpsilon = 1'b0;
	localparam logic [0:0] RegMode    = 1'b1;

	typedef struct packed {
		logic [CoordWidth-1:0] pos_x;
		logic [CoordWidth-1:0] pos_y;
		logic [CoordWidth-1:0] pos_z;
		logic [CoordWidth-1:0] tex_u;
		logic [CoordWidth-1:0] tex_v;
	} vertex_t;

	typedef struct packed {
		logic [OutWidth-1:0] tangent_x;
		logic [OutWidth-1:0] tangent_y;
		logic [OutWidth-1:0] tangent_z;
		logic                last_of_triangle;
	} tangent_t;

	// Controller to datapath
	typedef struct packed {
		logic       hold_vtx;     // store vertex into slot
		logic       slot;
		logic       load_tri;     // form deltas from held vertices and input
		logic       step_prod;    // products stage
		logic       step_norm;    // register magnitudes, signs, zero flag
		logic       step_sq;      // register shifted magnitudes, clear sum
		logic       sqrt_start;
		logic       div_start;
		logic [1:0] div_sel;
	} ttg_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic zero_out;
		logic sqrt_busy;
		logic div_busy;
	} ttg_stat_t;

endpackage

/* rtl/core/ttg_stream_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttg_stream_if: valid/ready channel
// Carries one payload of a generic type with a source and a sink modport.
// ----------------------------------------------------------------------------
interface ttg_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/ttg_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttg_datapath: tangent arithmetic
// Holds two vertices, forms deltas, determinant, tangent direction, then
// normalizes it through a bit-serial square root and a shared divider.
// ----------------------------------------------------------------------------
module ttg_datapath import ttg_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  ttg_cmd_t            cmd,
	input  vertex_t             vtx,
	input  logic [EpsWidth-1:0] epsilon_det,
	output ttg_stat_t           stat,
	output logic [OutWidth-1:0] tan_x,
	output logic [OutWidth-1:0] tan_y,
	output logic [OutWidth-1:0] tan_z
);

	localparam int CompWidth = 2 * ProdWidth + 2;
	localparam int MagWidth  = CompWidth - 1;
	localparam int LenWidth  = $clog2(MagWidth + 1);
	localparam int DivWidth  = NormBits + 15;
	localparam int DivCntW   = $clog2(DivWidth + 1);
	localparam int SqCntW    = $clog2(RootWidth + 1);

	logic [CoordWidth-1:0] pos_q [2][3];
	logic [CoordWidth-1:0] tex_q [2][2];

	logic signed [DeltaWidth-1:0] e1_s1 [3];
	logic signed [DeltaWidth-1:0] e2_s1 [3];
	logic signed [DeltaWidth-1:0] du12_s1, dv12_s1, du13_s1, dv13_s1;

	logic signed [ProdWidth-1:0] pa_s2 [3];
	logic signed [ProdWidth-1:0] pb_s2 [3];
	logic signed [ProdWidth-1:0] d1_s2, d2_s2;

	logic [MagWidth-1:0] mag_q [3];
	logic                neg_q [3];
	logic                zero_q;
	logic [NormBits-1:0] v_q [3];
	logic [SumWidth-1:0] sum_q;

	logic [RootWidth-1:0] root_q;
	logic [SqCntW-1:0]    sq_cnt_q;

	logic [DivWidth-1:0]  dnum_q;
	logic [RootWidth:0]   drem_q;
	logic [QuoWidth-1:0]  quo_q;
	logic [DivCntW-1:0]   div_cnt_q;
	logic [1:0]           div_sel_q;
	logic [OutWidth-1:0]  tan_q [3];

	// Store first two vertices
	always_ff @(posedge clk) begin
		if (cmd.hold_vtx) begin
			pos_q[cmd.slot][0] <= vtx.pos_x;
			pos_q[cmd.slot][1] <= vtx.pos_y;
			pos_q[cmd.slot][2] <= vtx.pos_z;
			tex_q[cmd.slot][0] <= vtx.tex_u;
			tex_q[cmd.slot][1] <= vtx.tex_v;
		end
	end

	// Form edges and UV deltas
	always_ff @(posedge clk) begin
		if (cmd.load_tri) begin
			e1_s1[0] <= DeltaWidth'($signed(pos_q[1][0])) - DeltaWidth'($signed(pos_q[0][0]));
			e1_s1[1] <= DeltaWidth'($signed(pos_q[1][1])) - DeltaWidth'($signed(pos_q[0][1]));
			e1_s1[2] <= DeltaWidth'($signed(pos_q[1][2])) - DeltaWidth'($signed(pos_q[0][2]));
			e2_s1[0] <= DeltaWidth'($signed(vtx.pos_x)) - DeltaWidth'($signed(pos_q[0][0]));
			e2_s1[1] <= DeltaWidth'($signed(vtx.pos_y)) - DeltaWidth'($signed(pos_q[0][1]));
			e2_s1[2] <= DeltaWidth'($signed(vtx.pos_z)) - DeltaWidth'($signed(pos_q[0][2]));
			du12_s1  <= DeltaWidth'($signed(tex_q[1][0])) - DeltaWidth'($signed(tex_q[0][0]));
			dv12_s1  <= DeltaWidth'($signed(tex_q[1][1])) - DeltaWidth'($signed(tex_q[0][1]));
			du13_s1  <= DeltaWidth'($signed(vtx.tex_u)) - DeltaWidth'($signed(tex_q[0][0]));
			dv13_s1  <= DeltaWidth'($signed(vtx.tex_v)) - DeltaWidth'($signed(tex_q[0][1]));
		end
	end

	// Register the eight products
	always_ff @(posedge clk) begin
		if (cmd.step_prod) begin
			for (int k = 0; k < 3; k++) begin
				pa_s2[k] <= dv13_s1 * e1_s1[k];
				pb_s2[k] <= dv12_s1 * e2_s1[k];
			end
			d1_s2 <= du12_s1 * dv13_s1;
			d2_s2 <= du13_s1 * dv12_s1;
		end
	end

	// Determinant test, component signs and magnitudes
	logic signed [DetWidth-1:0]   det;
	logic                         det_neg;
	logic [DetWidth-1:0]          det_mag;
	logic [DetWidth+EpsFrac-1:0]  det_sc;
	logic [EpsWidth+2*FracBits-1:0] eps_sc;
	logic                         below;
	logic signed [CompWidth-1:0]  comp [3];
	logic [MagWidth-1:0]          cmag [3];

	always_comb begin
		det     = DetWidth'(d1_s2) - DetWidth'(d2_s2);
		det_neg = det[DetWidth-1];
		det_mag = det_neg ? DetWidth'(-det) : DetWidth'(det);
		det_sc  = {det_mag, {EpsFrac{1'b0}}};
		eps_sc  = {epsilon_det, {(2*FracBits){1'b0}}};
		below   = (DetWidth+EpsFrac+EpsWidth+2*FracBits)'(det_sc)
			< (DetWidth+EpsFrac+EpsWidth+2*FracBits)'(eps_sc);
		for (int k = 0; k < 3; k++) begin
			comp[k] = CompWidth'(pa_s2[k]) - CompWidth'(pb_s2[k]);
			cmag[k] = comp[k][CompWidth-1] ? MagWidth'(-comp[k]) : MagWidth'(comp[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step_norm) begin
			for (int k = 0; k < 3; k++) begin
				mag_q[k] <= cmag[k];
				neg_q[k] <= comp[k][CompWidth-1] ^ det_neg;
			end
			zero_q <= below || ((cmag[0] | cmag[1] | cmag[2]) == '0);
		end
	end

	// Shift magnitudes so the largest is NormBits long
	logic [MagWidth-1:0] orm;
	logic [LenWidth-1:0] blen;
	logic [NormBits-1:0] vsh [3];

	always_comb begin
		orm  = mag_q[0] | mag_q[1] | mag_q[2];
		blen = '0;
		for (int i = 0; i < MagWidth; i++) begin
			if (orm[i]) blen = LenWidth'(i + 1);
		end
		for (int k = 0; k < 3; k++) begin
			if (blen > LenWidth'(NormBits))
				vsh[k] = NormBits'(mag_q[k] >> (blen - LenWidth'(NormBits)));
			else
				vsh[k] = NormBits'(mag_q[k] << (LenWidth'(NormBits) - blen));
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step_sq) begin
			for (int k = 0; k < 3; k++) v_q[k] <= vsh[k];
		end
	end

	// Sum of squares, one multiplier per lane then registered adder
	logic [2*NormBits-1:0] sq [3];
	always_comb begin
		for (int k = 0; k < 3; k++) sq[k] = v_q[k] * v_q[k];
	end

	// Bit-serial square root, one result bit a cycle; sum shifts out two bits a step
	logic [SumWidth+1:0] srem_q;
	logic [SumWidth+1:0] snext;
	logic                sfit;
	always_comb begin
		snext = {srem_q[SumWidth-1:0], sum_q[SumWidth-1 -: 2]};
		sfit  = snext >= (SumWidth+2)'({root_q, 2'b01});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_cnt_q <= '0;
		end else if (cmd.sqrt_start) begin
			sq_cnt_q <= SqCntW'(RootWidth);
		end else if (sq_cnt_q != '0) begin
			sq_cnt_q <= sq_cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step_sq) begin
			sum_q <= '0;
		end else if (cmd.sqrt_start) begin
			sum_q  <= SumWidth'(sq[0]) + SumWidth'(sq[1]) + SumWidth'(sq[2]);
			srem_q <= '0;
			root_q <= '0;
		end else if (sq_cnt_q != '0) begin
			sum_q  <= {sum_q[SumWidth-3:0], 2'b00};
			srem_q <= sfit ? snext - (SumWidth+2)'({root_q, 2'b01}) : snext;
			root_q <= {root_q[RootWidth-2:0], sfit};
		end
	end

	// Shared restoring divider: (v*16384 + n/2) / n, one bit a cycle
	logic [RootWidth:0] dtry;
	logic               dfit;
	always_comb begin
		dtry = {drem_q[RootWidth-1:0], dnum_q[DivWidth-1]};
		dfit = dtry >= (RootWidth+1)'(root_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (cmd.div_start) begin
			div_cnt_q <= DivCntW'(DivWidth);
		end else if (div_cnt_q != '0) begin
			div_cnt_q <= div_cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			dnum_q    <= DivWidth'({v_q[cmd.div_sel], 14'b0}) + DivWidth'(root_q >> 1);
			drem_q    <= '0;
			quo_q     <= '0;
			div_sel_q <= cmd.div_sel;
		end else if (div_cnt_q != '0) begin
			drem_q <= dfit ? dtry - (RootWidth+1)'(root_q) : dtry;
			dnum_q <= {dnum_q[DivWidth-2:0], 1'b0};
			quo_q  <= {quo_q[QuoWidth-2:0], dfit};
			if (div_cnt_q == DivCntW'(1)) begin
				tan_q[div_sel_q] <= neg_q[div_sel_q]
					? OutWidth'(-{1'b0, quo_q[QuoWidth-2:0], dfit})
					: OutWidth'({1'b0, quo_q[QuoWidth-2:0], dfit});
			end
		end
	end

	always_comb begin
		stat.zero_out  = zero_q;
		stat.sqrt_busy = sq_cnt_q != '0;
		stat.div_busy  = div_cnt_q != '0;
		tan_x = zero_q ? '0 : tan_q[0];
		tan_y = zero_q ? '0 : tan_q[1];
		tan_z = zero_q ? '0 : tan_q[2];
	end

endmodule

/* rtl/core/ttg_controller.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttg_controller: vertex sequencing
// Tracks the vertex slot, steps the datapath and emits three result copies.
// ----------------------------------------------------------------------------
module ttg_controller import ttg_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  logic      mode,
	input  ttg_stat_t stat,
	output ttg_cmd_t  cmd,
	output logic      out_valid,
	input  logic      out_ready,
	output logic      out_last
);

	typedef enum logic [2:0] {
		ST_IDLE, ST_PROD, ST_NORM, ST_SHIFT, ST_SQRT, ST_DIV, ST_EMIT
	} state_t;

	state_t     state_q;
	logic [1:0] slot_q;
	logic [1:0] comp_q;
	logic [1:0] copy_q;
	logic       started_q;
	logic       accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_valid = (state_q == ST_EMIT);
	assign out_last  = (copy_q == 2'd2);

	// Command decode
	always_comb begin
		cmd            = '0;
		cmd.slot       = slot_q[0];
		cmd.hold_vtx   = accept && mode && (slot_q != 2'd2);
		cmd.load_tri   = accept && mode && (slot_q == 2'd2);
		cmd.step_prod  = (state_q == ST_PROD);
		cmd.step_norm  = (state_q == ST_NORM);
		cmd.step_sq    = (state_q == ST_SHIFT);
		cmd.sqrt_start = (state_q == ST_SQRT) && !started_q;
		cmd.div_start  = (state_q == ST_DIV) && !started_q;
		cmd.div_sel    = comp_q;
	end

	// Hold state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			slot_q    <= '0;
			comp_q    <= '0;
			copy_q    <= '0;
			started_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (!mode) begin
							slot_q <= '0;
						end else if (slot_q == 2'd2) begin
							slot_q  <= '0;
							state_q <= ST_PROD;
						end else begin
							slot_q <= slot_q + 2'd1;
						end
					end
				end
				ST_PROD:  state_q <= ST_NORM;
				ST_NORM:  state_q <= ST_SHIFT;
				ST_SHIFT: begin
					copy_q  <= '0;
					state_q <= stat.zero_out ? ST_EMIT : ST_SQRT;
				end
				ST_SQRT: begin
					if (!started_q) begin
						started_q <= 1'b1;
					end else if (!stat.sqrt_busy) begin
						started_q <= 1'b0;
						comp_q    <= '0;
						state_q   <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (!started_q) begin
						started_q <= 1'b1;
					end else if (!stat.div_busy) begin
						started_q <= 1'b0;
						if (comp_q == 2'd2) begin
							state_q <= ST_EMIT;
						end else begin
							comp_q <= comp_q + 2'd1;
						end
					end
				end
				ST_EMIT: begin
					if (out_ready) begin
						copy_q <= copy_q + 2'd1;
						if (copy_q == 2'd2) state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* rtl/core/triangle_tangent_generator.sv */
`timescale 1ns / 1ps
// Vertices one and two are only stored; the third vertex starts the product,
// norm and shift steps, then the serial square root and three divides, one per
// component, before the result is emitted; a zero tangent skips to emit.
// No new vertex is taken until the last triangle's three results have left,
// and the serial root and the shared one-bit-a-cycle divider set the pace.
// Reset: arst_n clears slot, controller state and registers to reset values.
// ----------------------------------------------------------------------------
// triangle_tangent_generator: per-triangle tangent from positions and UVs
// Top level: APB register file, controller and datapath.
// ----------------------------------------------------------------------------
module triangle_tangent_generator import ttg_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	ttg_stream_if.sink          vtx_in,
	ttg_stream_if.source        tan_out,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [63:0]         pwdata,
	output logic [63:0]         prdata,
	output logic                pready
);

	logic [EpsWidth-1:0] eps_q;
	logic                mode_q;
	logic                wr;
	ttg_cmd_t            cmd;
	ttg_stat_t           stat;
	logic [OutWidth-1:0] tx, ty, tz;
	logic                last;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q  <= EpsWidth'(17);
			mode_q <= 1'b1;
		end else if (wr && paddr[2:0] == 3'b000) begin
			if (paddr[3] == RegEpsilon) eps_q <= pwdata[EpsWidth-1:0];
			else if (paddr[3] == RegMode) mode_q <= pwdata[0];
		end
	end

	// Register reads
	always_comb begin
		prdata = '0;
		if (paddr[3] == RegEpsilon) prdata = 64'(eps_q);
		else prdata = 64'(mode_q);
	end

	ttg_controller u_ctrl (
		.clk, .arst_n,
		.in_valid (vtx_in.valid),
		.in_ready (vtx_in.ready),
		.mode     (mode_q),
		.stat, .cmd,
		.out_valid(tan_out.valid),
		.out_ready(tan_out.ready),
		.out_last (last)
	);

	ttg_datapath u_dp (
		.clk, .arst_n, .cmd,
		.vtx         (vtx_in.data),
		.epsilon_det (eps_q),
		.stat,
		.tan_x (tx), .tan_y (ty), .tan_z (tz)
	);

	assign tan_out.data = '{tangent_x: tx, tangent_y: ty, tangent_z: tz,
		last_of_triangle: last};

endmodule

/* rtl/core/ttg_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttg_checker: port-level assertions
// Watches the top level's channels and register port.
// ----------------------------------------------------------------------------
module ttg_checker import ttg_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic out_last,
	input logic pready
);

	// No vertex taken while results wait
	a_no_in_during_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input ready while emitting");

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");

	// Last copy ends the burst
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_last |=> !out_valid)
		else $error("result after last");

	// Register port never waits
	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready) else $error("pready low");

endmodule

bind triangle_tangent_generator ttg_checker u_chk (
	.clk, .arst_n,
	.in_ready (vtx_in.ready),
	.out_valid(tan_out.valid), .out_ready(tan_out.ready),
	.out_last (tan_out.data.last_of_triangle),
	.pready
);

/* verif/triangle_tangent_generator_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_tangent_generator_test: self-checking bench for the tangent block
// Streams vertices through the block, predicts each triangle's Q1.14 tangent
// with an exact integer model, and checks every result transfer in order.
// Runs directed corner triangles, then random triangles under several
// threshold settings and idle/stall patterns, including a long output hold.
// ----------------------------------------------------------------------------
module triangle_tangent_generator_test;
	import ttg_pkg::*;

	localparam int LimitCycles = 600000;
	localparam int DrainCycles = 250;
	localparam int VertexBits  = $bits(vertex_t);
	localparam logic [3:0] AddrEpsilon = 4'(8 * RegEpsilon);
	localparam logic [3:0] AddrMode    = 4'(8 * RegMode);

	// Tangent predictor and in-order result store
	class tangent_scoreboard;
		tangent_t          pending[$];
		logic [EpsWidth-1:0] eps_thr;
		bit                tri_mode;
		int                slot;
		longint            held_pos[2][3];
		longint            held_uv[2][2];
		int                errors;

		function new();
			eps_thr  = 33'd17;
			tri_mode = 1'b1;
			slot     = 0;
			errors   = 0;
		endfunction

		function automatic int bit_length(longint unsigned val);
			int n;
			n = 0;
			while (val != 0) begin
				n++;
				val >>= 1;
			end
			return n;
		endfunction

		function automatic longint unsigned int_sqrt(longint unsigned val);
			longint unsigned res;
			longint unsigned b;
			res = 0;
			b   = 64'd1 << 62;
			while (b > val)
				b >>= 2;
			while (b != 0) begin
				if (val >= res + b) begin
					val -= res + b;
					res = (res >> 1) + b;
				end else begin
					res >>= 1;
				end
				b >>= 2;
			end
			return res;
		endfunction

		// Form the normalized tangent of the held triangle and the new vertex
		function automatic void form_tangent(longint p[3], longint t[2],
				output logic [OutWidth-1:0] tan[3]);
			longint du12, dv12, du13, dv13, det, comp, mag;
			longint unsigned m[3], v[3], sum, n, q;
			bit neg_det;
			bit sg[3];
			int k, len;
			for (k = 0; k < 3; k++)
				tan[k] = '0;
			du12 = held_uv[1][0] - held_uv[0][0];
			dv12 = held_uv[1][1] - held_uv[0][1];
			du13 = t[0] - held_uv[0][0];
			dv13 = t[1] - held_uv[0][1];
			det = du12 * dv13 - du13 * dv12;
			neg_det = det < 0;
			mag = neg_det ? -det : det;
			if (longint'(mag) < longint'({31'd0, eps_thr}))
				return;
			len = 0;
			for (k = 0; k < 3; k++) begin
				comp = dv13 * (held_pos[1][k] - held_pos[0][k])
					- dv12 * (p[k] - held_pos[0][k]);
				sg[k] = (comp < 0) != neg_det;
				m[k] = comp < 0 ? -comp : comp;
				if (bit_length(m[k]) > len)
					len = bit_length(m[k]);
			end
			if (len == 0)
				return;
			sum = 0;
			for (k = 0; k < 3; k++) begin
				v[k] = len > NormBits ? m[k] >> (len - NormBits) : m[k] << (NormBits - len);
				sum += v[k] * v[k];
			end
			n = int_sqrt(sum);
			for (k = 0; k < 3; k++) begin
				q = (v[k] * 16384 + n / 2) / n;
				tan[k] = sg[k] ? OutWidth'(-q) : OutWidth'(q);
			end
		endfunction

		// Note an accepted vertex and queue any tangent it completes
		function automatic void note_vertex(vertex_t vx);
			longint p[3], t[2];
			logic [OutWidth-1:0] tan[3];
			tangent_t res;
			int r, k;
			if (!tri_mode) begin
				slot = 0;
				return;
			end
			p[0] = longint'($signed(vx.pos_x));
			p[1] = longint'($signed(vx.pos_y));
			p[2] = longint'($signed(vx.pos_z));
			t[0] = longint'($signed(vx.tex_u));
			t[1] = longint'($signed(vx.tex_v));
			if (slot < 2) begin
				for (k = 0; k < 3; k++)
					held_pos[slot][k] = p[k];
				held_uv[slot][0] = t[0];
				held_uv[slot][1] = t[1];
				slot++;
				return;
			end
			form_tangent(p, t, tan);
			slot = 0;
			for (r = 0; r < 3; r++) begin
				res.tangent_x        = tan[0];
				res.tangent_y        = tan[1];
				res.tangent_z        = tan[2];
				res.last_of_triangle = (r == 2);
				pending = {pending, res};
			end
		endfunction

		// Compare one result transfer with the oldest expectation
		function automatic void check_tangent(tangent_t got);
			tangent_t exp_t;
			if (pending.size() == 0) begin
				$error("unexpected tangent transfer %h", got);
				errors++;
				return;
			end
			exp_t = pending.pop_front();
			if (got.tangent_x !== exp_t.tangent_x) begin
				$error("tangent_x: expected %h, got %h", exp_t.tangent_x, got.tangent_x);
				errors++;
			end
			if (got.tangent_y !== exp_t.tangent_y) begin
				$error("tangent_y: expected %h, got %h", exp_t.tangent_y, got.tangent_y);
				errors++;
			end
			if (got.tangent_z !== exp_t.tangent_z) begin
				$error("tangent_z: expected %h, got %h", exp_t.tangent_z, got.tangent_z);
				errors++;
			end
			if (got.last_of_triangle !== exp_t.last_of_triangle) begin
				$error("last_of_triangle: expected %b, got %b",
					exp_t.last_of_triangle, got.last_of_triangle);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [3:0] paddr;
	logic [63:0] pwdata, prdata;

	ttg_stream_if #(.payload_t(vertex_t))  vtx_if ();
	ttg_stream_if #(.payload_t(tangent_t)) tan_if ();

	tangent_scoreboard sb;
	int send_idle_pct;
	int recv_stall_pct;
	int hold_cycles;
	int cycle_count;

	triangle_tangent_generator uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.vtx_in  (vtx_if),
		.tan_out (tan_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Drive output ready: long hold first, else random stalls
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			tan_if.ready <= 1'b0;
		end else begin
			tan_if.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Check each result transfer
	always @(posedge clk) begin
		if (arst_n && tan_if.valid && tan_if.ready)
			sb.check_tangent(tan_if.data);
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LimitCycles) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic vertex_t mk_vertex(int x, int y, int z, int u, int v);
		vertex_t vx;
		vx.pos_x = 16'(x);
		vx.pos_y = 16'(y);
		vx.pos_z = 16'(z);
		vx.tex_u = 16'(u);
		vx.tex_v = 16'(v);
		return vx;
	endfunction

	// Offer one vertex and hold it until the transfer
	task automatic send_vertex(vertex_t vx);
		while ($urandom_range(99) < send_idle_pct) begin
			vtx_if.valid <= 1'b0;
			@(posedge clk);
		end
		vtx_if.valid <= 1'b1;
		vtx_if.data  <= vx;
		do
			@(posedge clk);
		while (!vtx_if.ready);
		sb.note_vertex(vx);
	endtask

	task automatic send_tri(vertex_t a, vertex_t b, vertex_t c);
		send_vertex(a);
		send_vertex(b);
		send_vertex(c);
	endtask

	// Wait for every expected result, then let the block settle
	task automatic drain();
		vtx_if.valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_reg(logic [3:0] addr, logic [63:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr == AddrEpsilon)
			sb.eps_thr = value[EpsWidth-1:0];
		else
			sb.tri_mode = value[0];
	endtask

	// Random vertex: full range, or a small offset from a base for near-threshold dets
	function automatic vertex_t rand_vertex(vertex_t base, int kind);
		vertex_t vx;
		if (kind == 0) begin
			vx = vertex_t'(VertexBits'({$urandom, $urandom, $urandom}));
		end else begin
			vx.pos_x = base.pos_x + 16'($urandom_range(256) - 128);
			vx.pos_y = base.pos_y + 16'($urandom_range(256) - 128);
			vx.pos_z = base.pos_z + 16'($urandom_range(256) - 128);
			vx.tex_u = base.tex_u + 16'($urandom_range(16) - 8);
			vx.tex_v = base.tex_v + 16'($urandom_range(16) - 8);
		end
		return vx;
	endfunction

	task automatic random_triangles(int count);
		vertex_t a, b, c;
		int kind;
		for (int i = 0; i < count; i++) begin
			kind = $urandom_range(9) < 6 ? 0 : 1;
			a = vertex_t'(VertexBits'({$urandom, $urandom, $urandom}));
			b = rand_vertex(a, kind);
			if ($urandom_range(9) == 0)
				c = b;
			else
				c = rand_vertex(a, kind);
			send_tri(a, b, c);
		end
	endtask

	initial begin
		sb = new();
		arst_n         = 1'b0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		vtx_if.valid   = 1'b0;
		vtx_if.data    = '0;
		tan_if.ready   = 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_cycles    = 0;
		cycle_count    = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: plain, extreme, below-threshold, zero-vector and negative-det triangles
		send_tri(mk_vertex(0, 0, 0, 0, 0), mk_vertex(4096, 0, 0, 4096, 0),
			mk_vertex(0, 4096, 0, 0, 4096));
		send_tri(mk_vertex(-32768, -32768, -32768, -32768, -32768),
			mk_vertex(32767, 32767, 32767, 32767, -32768),
			mk_vertex(-32768, 32767, 0, -32768, 32767));
		send_tri(mk_vertex(1, 2, 3, 5, 5), mk_vertex(900, -40, 7, 5, 5),
			mk_vertex(-3, 600, 2000, 5, 5));
		send_tri(mk_vertex(100, 200, 300, 0, 0), mk_vertex(100, 200, 300, 4096, 0),
			mk_vertex(100, 200, 300, 0, 4096));
		send_tri(mk_vertex(0, 0, 0, 0, 0), mk_vertex(4096, 0, 0, 0, 4096),
			mk_vertex(0, 4096, 0, 4096, 0));
		send_tri(mk_vertex(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555),
			mk_vertex(16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa),
			mk_vertex(16'hffff, 16'h0000, 16'h7fff, 16'h8000, 16'h0001));
		drain();

		// Zero threshold with zero det takes the positive sign
		write_reg(AddrEpsilon, 64'd0);
		send_tri(mk_vertex(0, 0, 0, 0, 0), mk_vertex(100, 0, 0, 1, 1),
			mk_vertex(0, 300, 0, 2, 2));
		drain();

		// Drop to non-triangle mode mid-triangle; discarded vertices clear the slot
		send_vertex(mk_vertex(7, 7, 7, 7, 7));
		drain();
		write_reg(AddrMode, 64'd0);
		send_vertex(mk_vertex(1, 1, 1, 1, 1));
		send_vertex(mk_vertex(2, 2, 2, 2, 2));
		drain();
		write_reg(AddrMode, 64'd1);
		write_reg(AddrEpsilon, {31'd0, 33'h1ffffffff});
		send_tri(mk_vertex(0, 0, 0, -32768, -32768), mk_vertex(32767, 0, 0, 32767, -32768),
			mk_vertex(0, 32767, 0, -32768, 32767));
		drain();

		// Random triangles across idle patterns and thresholds
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 0;  recv_stall_pct = 0;
					write_reg(AddrEpsilon, 64'd17);
					hold_cycles = 800;
				end
				1: begin
					send_idle_pct = 81; recv_stall_pct = 0;
					write_reg(AddrEpsilon, 64'd0);
				end
				2: begin
					send_idle_pct = 0;  recv_stall_pct = 81;
					write_reg(AddrEpsilon, {31'd0, 33'($urandom_range(4096))});
				end
				default: begin
					send_idle_pct = 15; recv_stall_pct = 15;
					write_reg(AddrEpsilon, 64'd17);
				end
			endcase
			random_triangles(15);
			drain();
		end

		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
